>>> rtl/lrr_pkg.sv
`default_nettype none

package lrr_pkg;

  localparam int MAX_ORDER  = 32;
  localparam int COEFF_BITS = 15;
  localparam int SAMPLE_W   = 32;
  localparam int TAP_W      = $clog2(MAX_ORDER);
  localparam int ORDER_W    = 6;
  localparam int SHIFT_W    = 4;
  localparam int PROD_W     = COEFF_BITS + SAMPLE_W;
  // One guard bit beyond log2 of the tap count keeps the running sum exact.
  localparam int ACC_W      = PROD_W + TAP_W + 1;

  localparam int OPCODE_W   = 2;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 6;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 32;

  localparam logic [OPCODE_W-1:0] OP_LOAD     = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_WARMUP   = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_RESIDUAL = 2'd2;

  localparam logic [CFG_ADDR_W-1:0] REG_PRED_ORDER  = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_QUANT_SHIFT = 1'd1;

endpackage

`default_nettype wire

>>> rtl/lrr_ram.sv
`default_nettype none

module lrr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/lrr_mac.sv
`default_nettype none

module lrr_mac
  import lrr_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         clear,
  input  wire logic                         in_valid,
  input  wire logic signed [COEFF_BITS-1:0] coeff,
  input  wire logic signed [SAMPLE_W-1:0]   sample,
  output logic                              busy,
  output logic signed [ACC_W-1:0]           acc
);

  logic signed [PROD_W-1:0] prod;
  logic                     prod_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      prod <= coeff * sample;
    end
    if (clear) begin
      acc <= '0;
    end else if (prod_valid) begin
      acc <= acc + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
    end
  end

  assign busy = prod_valid;

endmodule

`default_nettype wire

>>> rtl/lpc_residual_restore_top.sv
`default_nettype none

// LPC synthesis filter. Coefficient loads end when taken; warm-up samples, and
// residuals at order zero, go straight to the write-back step. Other residuals use
// the effective order (pred_order, capped at 32): one multiply-accumulate unit walks
// the taps one per cycle, fed by a coefficient RAM and a circular sample-history
// RAM (registered reads), followed by a drain of the read and multiply stages and
// a step to add the residual and write the history back.
// That last step stretches while the output register still holds an untaken beat.
// The input is taken only between items; a finished sample waits in the output
// register so the next item can be accepted while it is not yet taken.

module lpc_residual_restore_top
  import lrr_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  // Configuration write port.
  input  wire logic                    cfg_we,
  input  wire logic [CFG_ADDR_W-1:0]   cfg_addr,
  input  wire logic [CFG_DATA_W-1:0]   cfg_wdata,
  // Input stream.
  input  wire logic                    s_tvalid,
  output logic                         s_tready,
  // s_tdata: coeff_index[4:0], coeff_value[19:5], value[51:20], zero pad [55:52]
  input  wire logic [IN_DATA_W-1:0]    s_tdata,
  // s_tuser: opcode[1:0]
  input  wire logic [OPCODE_W-1:0]     s_tuser,
  input  wire logic                    s_tlast,
  // Output stream.
  output logic                         m_tvalid,
  input  wire logic                    m_tready,
  // m_tdata: sample[31:0]
  output logic [OUT_DATA_W-1:0]        m_tdata,
  output logic                         m_tlast
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MAC   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0] state, state_next;

  logic [ORDER_W-1:0] pred_order;
  logic [SHIFT_W-1:0] quant_shift;

  logic [OPCODE_W-1:0] op;
  logic [SAMPLE_W-1:0] value;
  logic                last;

  logic [TAP_W-1:0]     tap;
  logic [TAP_W-1:0]     last_tap;
  logic [TAP_W-1:0]     head;
  logic [MAX_ORDER-1:0] hist_valid;
  logic                 rd_valid;
  logic                 rd_hist_valid;

  logic [TAP_W-1:0]      in_cidx;
  logic [COEFF_BITS-1:0] in_cval;
  logic [SAMPLE_W-1:0]   in_value;
  logic                  accept;
  logic [ORDER_W-1:0]    order_eff;

  logic [TAP_W-1:0]      hist_raddr;
  logic [COEFF_BITS-1:0] coeff_rdata;
  logic [SAMPLE_W-1:0]   hist_rdata;
  logic [SAMPLE_W-1:0]   mac_sample;
  logic                  mac_busy;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_shifted;
  logic [SAMPLE_W-1:0]   result;
  logic                  out_free;
  logic                  finish;

  assign in_cidx  = s_tdata[TAP_W-1:0];
  assign in_cval  = s_tdata[TAP_W +: COEFF_BITS];
  assign in_value = s_tdata[TAP_W+COEFF_BITS +: SAMPLE_W];

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign finish   = (state == ST_DONE) && out_free;

  // Orders above the table depth saturate.
  assign order_eff = (pred_order > ORDER_W'(MAX_ORDER)) ? ORDER_W'(MAX_ORDER) : pred_order;

  // History entry j is the (j+1)-th most recent sample.
  assign hist_raddr = head - TAP_W'(1) - tap;

  always_ff @(posedge clk) begin
    if (rst) begin
      pred_order  <= ORDER_W'(1);
      quant_shift <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_PRED_ORDER:  pred_order  <= cfg_wdata[ORDER_W-1:0];
        REG_QUANT_SHIFT: quant_shift <= cfg_wdata[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (s_tuser == OP_WARMUP) begin
            state_next = ST_DONE;
          end else if (s_tuser == OP_RESIDUAL) begin
            state_next = (order_eff == '0) ? ST_DONE : ST_MAC;
          end
        end
      end
      ST_MAC: begin
        if (tap == last_tap) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_valid && !mac_busy) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      head       <= '0;
      hist_valid <= '0;
      rd_valid   <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= (state == ST_MAC);
      if (finish) begin
        head             <= head + TAP_W'(1);
        hist_valid[head] <= 1'b1;
        m_tvalid         <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op       <= s_tuser;
      value    <= in_value;
      last     <= s_tlast;
      tap      <= '0;
      last_tap <= TAP_W'(order_eff - ORDER_W'(1));
    end else if (state == ST_MAC) begin
      tap <= tap + TAP_W'(1);
    end
    rd_hist_valid <= hist_valid[hist_raddr];
    if (finish) begin
      m_tdata <= result;
      m_tlast <= last;
    end
  end

  lrr_ram #(
    .WIDTH (COEFF_BITS),
    .DEPTH (MAX_ORDER)
  ) u_coeff_ram (
    .clk   (clk),
    .we    (accept && (s_tuser == OP_LOAD)),
    .waddr (in_cidx),
    .wdata (in_cval),
    .raddr (tap),
    .rdata (coeff_rdata)
  );

  lrr_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_ORDER)
  ) u_hist_ram (
    .clk   (clk),
    .we    (finish),
    .waddr (head),
    .wdata (result),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  // History slots never written since reset read as zero.
  assign mac_sample = rd_hist_valid ? hist_rdata : '0;

  lrr_mac u_mac (
    .clk      (clk),
    .rst      (rst),
    .clear    (accept),
    .in_valid (rd_valid),
    .coeff    ($signed(coeff_rdata)),
    .sample   ($signed(mac_sample)),
    .busy     (mac_busy),
    .acc      (acc)
  );

  assign acc_shifted = acc >>> quant_shift;
  assign result = (op == OP_WARMUP) ? value : value + acc_shifted[SAMPLE_W-1:0];

endmodule

`default_nettype wire

>>> verif/tb_top.sv
module tb_top
  import lrr_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 2 * MAX_ORDER + 16;
  localparam int DRAIN_BOUND   = 40000;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int HOLD_CYCLES   = 300;

  typedef struct packed {
    logic [OPCODE_W-1:0]   opcode;
    logic [TAP_W-1:0]      coeff_index;
    logic [COEFF_BITS-1:0] coeff_value;
    logic [SAMPLE_W-1:0]   value;
    logic                  block_end;
  } lpc_item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last;
  } restored_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  // s_tdata: coeff_index[4:0], coeff_value[19:5], value[51:20], zero pad [55:52]
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  // s_tuser: opcode[1:0]
  logic [OPCODE_W-1:0]   s_tuser = '0;
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // m_tdata: sample[31:0]
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;

  lpc_residual_restore_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  // Filter state as the testbench believes it to be.
  logic signed [COEFF_BITS-1:0] tap_coeff [MAX_ORDER];
  logic signed [SAMPLE_W-1:0]   recent [MAX_ORDER];
  logic [ORDER_W-1:0]           order_reg = 6'd1;
  logic [SHIFT_W-1:0]           shift_reg = 4'd0;

  // Taps that the stimulus has loaded so far; residuals never read any other.
  bit tap_seen [MAX_ORDER];

  lpc_item_t pending_items [$];
  restored_t restored_q [$];
  lpc_item_t offered;

  int queued_total = 0;
  int live_items = 0;
  int ignored_items = 0;
  int beats_in = 0;
  int samples_checked = 0;
  int fails = 0;
  int cycle_count = 0;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  bit hold_request = 1'b0;
  bit hold_used = 1'b0;
  int hold_left = 0;

  initial begin
    for (int j = 0; j < MAX_ORDER; j++) begin
      tap_coeff[j] = '0;
      recent[j] = '0;
    end
  end

  initial begin
    forever #2 clk = ~clk;
  end

  task automatic restore_sample(input lpc_item_t it);
    logic signed [63:0] acc;
    logic signed [63:0] scaled;
    logic [SAMPLE_W-1:0] result;
    int span;
    acc = '0;
    case (it.opcode)
      OP_LOAD: begin
        if (it.coeff_index < MAX_ORDER) tap_coeff[it.coeff_index] = it.coeff_value;
        return;
      end
      OP_WARMUP: begin
        result = it.value;
      end
      OP_RESIDUAL: begin
        span = (order_reg > MAX_ORDER) ? MAX_ORDER : order_reg;
        for (int j = 0; j < span; j++) acc += tap_coeff[j] * recent[j];
        scaled = acc >>> shift_reg;
        result = it.value + scaled[SAMPLE_W-1:0];
      end
      default: begin
        return;
      end
    endcase
    for (int k = MAX_ORDER - 1; k > 0; k--) recent[k] = recent[k-1];
    recent[0] = result;
    restored_q.push_back('{sample: result, last: it.block_end});
  endtask

  // Input driver: valid is only dropped or replaced once the current beat is taken.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        restore_sample(offered);
        beats_in++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          offered = pending_items.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {4'b0, offered.value, offered.coeff_value, offered.coeff_index};
          s_tuser <= offered.opcode;
          s_tlast <= offered.block_end;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output ready, with one long hold-off so the block backs up into its input.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_request && !hold_used) begin
      m_tready <= 1'b0;
      hold_left++;
      if (hold_left >= HOLD_CYCLES) hold_used = 1'b1;
    end else begin
      m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin : sample_monitor
    restored_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (restored_q.size() == 0) begin
        $error("unexpected output beat: sample %h last %b", m_tdata, m_tlast);
        fails++;
      end else begin
        want = restored_q.pop_front();
        samples_checked++;
        if (m_tdata !== want.sample) begin
          $error("sample mismatch: expected %h, actual %h", want.sample, m_tdata);
          fails++;
        end
        if (m_tlast !== want.last) begin
          $error("sample_last mismatch: expected %b, actual %b", want.last, m_tlast);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $error("run stopped after %0d cycles with %0d samples outstanding",
             cycle_count, restored_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (addr == REG_PRED_ORDER) order_reg = data[ORDER_W-1:0];
    else shift_reg = data[SHIFT_W-1:0];
  endtask

  task automatic add_item(input logic [OPCODE_W-1:0] op, input logic [TAP_W-1:0] idx,
                          input logic [COEFF_BITS-1:0] cv, input logic [SAMPLE_W-1:0] val,
                          input logic last);
    pending_items.push_back('{opcode: op, coeff_index: idx, coeff_value: cv,
                              value: val, block_end: last});
    queued_total++;
    if (op == OP_UNUSED) ignored_items++;
    else live_items++;
    if (op == OP_LOAD) tap_seen[idx] = 1'b1;
  endtask

  function automatic bit taps_ready(input int span);
    for (int j = 0; j < span; j++) if (!tap_seen[j]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [COEFF_BITS-1:0] rand_coeff();
    case ($urandom_range(9))
      0: return 15'h4000;
      1: return 15'h3FFF;
      2, 3, 4: return 15'($urandom);
      default: return 15'($urandom_range(1023)) - 15'd512;
    endcase
  endfunction

  function automatic logic [SAMPLE_W-1:0] rand_value();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3, 4, 5: return $urandom;
      default: return 32'($urandom_range(65535)) - 32'd32768;
    endcase
  endfunction

  // One frame as a decoder would send it: taps (sometimes reusing loaded ones), warm-up history, then residuals.
  task automatic queue_frame(input int span);
    int n_res;
    bit reuse;
    reuse = ($urandom_range(3) == 0) && taps_ready(span);
    if (!reuse) begin
      for (int j = 0; j < span; j++) add_item(OP_LOAD, 5'(j), rand_coeff(), $urandom, 1'b0);
    end
    for (int j = 0; j < span; j++) begin
      add_item(OP_WARMUP, 5'($urandom), 15'($urandom), rand_value(), 1'b0);
    end
    n_res = $urandom_range(20, 3);
    for (int k = 0; k < n_res; k++) begin
      add_item(OP_RESIDUAL, 5'($urandom), 15'($urandom), rand_value(), k == n_res - 1);
    end
  endtask

  task automatic queue_noise(input int span);
    lpc_item_t it;
    int n;
    n = $urandom_range(4, 1);
    for (int k = 0; k < n; k++) begin
      it = 55'({$urandom, $urandom});
      if (it.opcode == OP_RESIDUAL && !taps_ready(span)) it.opcode = OP_WARMUP;
      add_item(it.opcode, it.coeff_index, it.coeff_value, it.value, it.block_end);
    end
  endtask

  // Waits until every item is taken and every sample checked, then lets
  // an item without a result finish before the next register write.
  task automatic drain();
    int waited;
    waited = 0;
    while ((beats_in != queued_total || restored_q.size() != 0) && waited < DRAIN_BOUND) begin
      @(posedge clk);
      waited++;
    end
    if (beats_in != queued_total || restored_q.size() != 0) begin
      $error("%0d items not taken, %0d samples never arrived",
             queued_total - beats_in, restored_q.size());
      fails++;
      restored_q.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [CFG_DATA_W-1:0] order_w,
                           input logic [CFG_DATA_W-1:0] shift_w,
                           input int src_pct, input int sink_pct,
                           input int n_items, input bit squeeze);
    int span;
    int first;
    write_reg(REG_PRED_ORDER, order_w);
    write_reg(REG_QUANT_SHIFT, shift_w);
    span = (order_w > MAX_ORDER) ? MAX_ORDER : order_w;
    src_idle_pct = src_pct;
    sink_stall_pct = sink_pct;
    hold_request = squeeze;
    first = live_items;
    queue_frame(span);
    while (live_items - first < n_items) begin
      if ($urandom_range(99) < 85) queue_frame(span);
      else queue_noise(span);
    end
    drain();
    src_idle_pct = 0;
    sink_stall_pct = 0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Zero order: the prediction is empty and every residual comes out unchanged.
    write_reg(REG_PRED_ORDER, 6'd0);
    write_reg(REG_QUANT_SHIFT, 6'd0);
    add_item(OP_WARMUP, 5'd0, 15'd0, 32'h7FFF_FFFF, 1'b0);
    add_item(OP_WARMUP, 5'h1F, 15'h7FFF, 32'h8000_0000, 1'b1);
    add_item(OP_WARMUP, 5'd0, 15'd0, 32'hFFFF_FFFF, 1'b0);
    add_item(OP_RESIDUAL, 5'd0, 15'd0, 32'h7FFF_FFFF, 1'b0);
    add_item(OP_UNUSED, 5'h1F, 15'h7FFF, 32'hFFFF_FFFF, 1'b1);
    add_item(OP_RESIDUAL, 5'd0, 15'd0, 32'h8000_0000, 1'b1);
    add_item(OP_LOAD, 5'd0, 15'h4000, 32'd0, 1'b0);
    add_item(OP_LOAD, 5'd1, 15'h3FFF, 32'hFFFF_FFFF, 1'b1);
    add_item(OP_LOAD, 5'h1F, 15'h3FFF, 32'd0, 1'b0);
    drain();

    // Two extreme taps at the largest shift; the first residual wraps past the top.
    write_reg(REG_PRED_ORDER, 6'd2);
    write_reg(REG_QUANT_SHIFT, 6'd15);
    add_item(OP_WARMUP, 5'd0, 15'd0, 32'h8000_0000, 1'b0);
    add_item(OP_WARMUP, 5'd0, 15'd0, 32'h8000_0000, 1'b0);
    add_item(OP_RESIDUAL, 5'd0, 15'd0, 32'h7FFF_FFFF, 1'b0);
    add_item(OP_WARMUP, 5'd0, 15'd0, 32'h7FFF_FFFF, 1'b0);
    add_item(OP_WARMUP, 5'd0, 15'd0, 32'h7FFF_FFFF, 1'b0);
    add_item(OP_UNUSED, 5'd0, 15'd0, 32'h1234_5678, 1'b0);
    add_item(OP_RESIDUAL, 5'd0, 15'd0, 32'd0, 1'b0);
    add_item(OP_RESIDUAL, 5'd0, 15'd0, 32'h8000_0000, 1'b1);
    drain();

    run_phase(6'd32, 6'd15, 0, 0, 60, 1'b0);
    run_phase(6'd8, 6'd12, 68, 0, 100, 1'b0);
    // Orders above the table size saturate; upper shift bits are dropped.
    run_phase(6'd63, 6'h3F, 0, 68, 100, 1'b0);
    run_phase(6'd1, 6'd0, 21, 21, 100, 1'b0);
    run_phase(6'd12, 6'd9, 0, 0, 100, 1'b1);
    run_phase(6'd33, 6'd5, 21, 21, 40, 1'b0);

    $display("Accepted %0d input beats (%0d with the unused opcode), checked %0d samples.",
             beats_in, ignored_items, samples_checked);
    $display("Orders 0 to 63 and shifts 0 to 15 ran with source gaps, sink stalls "
             , "and one long output hold-off.");
    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
